/* rtl/positional_ordered_list_macros.svh */
// Assertion shorthands; every use sees clk_i and rst_ni in the enclosing module.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

`define POL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

`define POL_ASSERT_NEVER(label, expr) \
  `POL_ASSERT(label, !(expr))

`endif

/* rtl/pol_pkg.sv */
package pol_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_LIST   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    SEL_HOLD      = 3'd0,
    SEL_LOAD      = 3'd1,
    SEL_TAKE_PREV = 3'd2,
    SEL_TAKE_NEXT = 3'd3,
    SEL_TAKE_HEAD = 3'd4
  } cell_sel_e;

endpackage

/* rtl/pol_cell.sv */
module pol_cell #(
  parameter int unsigned VALUE_WIDTH = pol_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  pol_pkg::cell_sel_e            sel_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic signed [VALUE_WIDTH-1:0] prev_i,
  input  logic signed [VALUE_WIDTH-1:0] next_i,
  input  logic signed [VALUE_WIDTH-1:0] head_i,
  output logic signed [VALUE_WIDTH-1:0] q_o
);
  import pol_pkg::*;

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;

  always_comb begin
    unique case (sel_i)
      SEL_HOLD:      value_d = value_q;
      SEL_LOAD:      value_d = value_i;
      SEL_TAKE_PREV: value_d = prev_i;
      SEL_TAKE_NEXT: value_d = next_i;
      SEL_TAKE_HEAD: value_d = head_i;
      default:       value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign q_o = value_q;

endmodule

/* rtl/pol_ctrl.sv */
module pol_ctrl #(
  parameter int unsigned DEPTH       = pol_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = pol_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned POS_W       = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [VALUE_WIDTH-1:0] item_value_i,
  input  logic [POS_W-1:0]              item_position_i,
  input  logic signed [VALUE_WIDTH-1:0] cell_q_i [DEPTH],
  output pol_pkg::cell_sel_e            cell_sel_o [DEPTH],
  output logic                          strobe_o,
  output logic [2:0]                    status_o,
  output logic signed [VALUE_WIDTH-1:0] out_value_o,
  output logic [POS_W-1:0]              found_position_o,
  output logic [POS_W-1:0]              entry_count_o,
  output logic                          last_o
);
  import pol_pkg::*;

  localparam logic [POS_W-1:0] DepthP = POS_W'(DEPTH);

  state_e                        state_q, state_d;
  logic [POS_W-1:0]              occ_q, occ_d;
  logic [POS_W-1:0]              idx_q, idx_d;
  logic [POS_W-1:0]              fpos_q, fpos_d;
  logic                          found_q, found_d;
  logic                          list_q, list_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;

  logic                          strobe_q, strobe_d;
  status_e                       status_q, status_d;
  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic [POS_W-1:0]              rpos_q, rpos_d;
  logic [POS_W-1:0]              count_q, count_d;
  logic                          last_q, last_d;

  mode_e                         mode;
  logic                          accept;
  logic                          ins_ok;
  logic                          del_ok;
  logic                          scan_go;
  logic                          scan_end;
  logic                          head_hit;
  logic [POS_W-1:0]              occ_m1;
  logic [POS_W-1:0]              pos_m1;
  logic signed [VALUE_WIDTH-1:0] del_value;

  assign mode     = mode_e'(mode_i);
  assign accept   = start_i && !busy_o;
  assign occ_m1   = occ_q - 1'b1;
  assign pos_m1   = item_position_i - 1'b1;
  assign ins_ok   = (item_position_i <= occ_q) && (occ_q != DepthP);
  assign del_ok   = (occ_q != '0) && (item_position_i != '0) && (item_position_i <= occ_q);
  assign scan_go  = ((mode == MODE_SEARCH) || (mode == MODE_LIST)) && (occ_q != '0);
  assign scan_end = (state_q == S_SCAN) && (idx_q == occ_m1);
  assign head_hit = (cell_q_i[0] == key_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && scan_go) state_d = S_SCAN;
      S_SCAN: if (scan_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q == S_SCAN);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_sel_o[i] = SEL_HOLD;
      if (state_q == S_SCAN) begin
        if (POS_W'(i) == occ_m1) begin
          cell_sel_o[i] = SEL_TAKE_HEAD;
        end else if (POS_W'(i) < occ_m1) begin
          cell_sel_o[i] = SEL_TAKE_NEXT;
        end
      end else if (accept && (mode == MODE_INSERT) && ins_ok) begin
        if (POS_W'(i) == item_position_i) begin
          cell_sel_o[i] = SEL_LOAD;
        end else if (POS_W'(i) > item_position_i) begin
          cell_sel_o[i] = SEL_TAKE_PREV;
        end
      end else if (accept && (mode == MODE_DELETE) && del_ok) begin
        if ((POS_W'(i) >= pos_m1) && (i < DEPTH - 1)) begin
          cell_sel_o[i] = SEL_TAKE_NEXT;
        end
      end
    end
  end

  always_comb begin
    del_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (POS_W'(i) == pos_m1) begin
        del_value = del_value | cell_q_i[i];
      end
    end
  end

  always_comb begin
    occ_d    = occ_q;
    idx_d    = idx_q;
    fpos_d   = fpos_q;
    found_d  = found_q;
    list_d   = list_q;
    key_d    = key_q;
    strobe_d = 1'b0;
    status_d = STAT_OK;
    value_d  = '0;
    rpos_d   = '0;
    last_d   = 1'b1;
    if (state_q == S_SCAN) begin
      idx_d = idx_q + 1'b1;
      if (list_q) begin
        strobe_d = 1'b1;
        value_d  = cell_q_i[0];
        rpos_d   = idx_q + 1'b1;
        last_d   = scan_end;
      end else begin
        if (head_hit && !found_q) begin
          found_d = 1'b1;
          fpos_d  = idx_q + 1'b1;
        end
        if (scan_end) begin
          strobe_d = 1'b1;
          if (found_q) begin
            rpos_d = fpos_q;
          end else if (head_hit) begin
            rpos_d = idx_q + 1'b1;
          end else begin
            status_d = STAT_NOTFOUND;
          end
        end
      end
    end else if (accept) begin
      unique case (mode)
        MODE_INSERT: begin
          strobe_d = 1'b1;
          if (item_position_i > occ_q) begin
            status_d = STAT_BADPOS;
          end else if (occ_q == DepthP) begin
            status_d = STAT_FULL;
          end else begin
            occ_d = occ_q + 1'b1;
          end
        end
        MODE_DELETE: begin
          strobe_d = 1'b1;
          if (occ_q == '0) begin
            status_d = STAT_EMPTY;
          end else if (!del_ok) begin
            status_d = STAT_BADPOS;
          end else begin
            value_d = del_value;
            occ_d   = occ_m1;
          end
        end
        MODE_SEARCH, MODE_LIST: begin
          if (occ_q == '0) begin
            strobe_d = 1'b1;
            status_d = STAT_EMPTY;
          end else begin
            idx_d   = '0;
            key_d   = item_value_i;
            list_d  = (mode == MODE_LIST);
            found_d = 1'b0;
            fpos_d  = '0;
          end
        end
        default: strobe_d = 1'b0;
      endcase
    end
    count_d = occ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    fpos_q   <= fpos_d;
    found_q  <= found_d;
    list_q   <= list_d;
    key_q    <= key_d;
    status_q <= status_d;
    value_q  <= value_d;
    rpos_q   <= rpos_d;
    count_q  <= count_d;
    last_q   <= last_d;
  end

  assign strobe_o         = strobe_q;
  assign status_o         = status_q;
  assign out_value_o      = value_q;
  assign found_position_o = rpos_q;
  assign entry_count_o    = count_q;
  assign last_o           = last_q;

`include "positional_ordered_list_macros.svh"

  `POL_ASSERT_NEVER(a_occ_bound, occ_q > DepthP)
  `POL_ASSERT(a_ins_grows, accept && (mode == MODE_INSERT) && ins_ok |=> occ_q == $past(occ_q) + 1'b1)
  `POL_ASSERT(a_scan_keeps_occ, (state_q == S_SCAN) |=> occ_q == $past(occ_q))
  `POL_ASSERT(a_list_burst, strobe_q && !last_q |=> strobe_q && (state_q == S_SCAN || last_q))

endmodule

/* rtl/positional_ordered_list.sv */
// Ordered list of up to DEPTH signed values held in a row of shifting cells.
// Pulse start_i while busy_o is low to issue a request; each result appears
// for one cycle with strobe_o high and cannot be stalled. Insert and delete
// update the row and register their report at the same clock edge; the
// report appears in the cycle after the request, and a new request may
// follow in the very next cycle. Search and list rotate the occupied cells
// once past the head, one cell per cycle, holding busy_o until the rotation
// ends: list gives one beat per entry on consecutive cycles, with last_o on
// the final one; search gives a single beat after the rotation completes.
// On an empty list every request answers in the next cycle with a single beat.
module positional_ordered_list #(
  parameter int unsigned DEPTH       = pol_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = pol_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned POS_W      = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [VALUE_WIDTH-1:0] item_value_i,
  input  logic [POS_W-1:0]              item_position_i,
  output logic                          strobe_o,
  output logic [2:0]                    status_o,
  output logic signed [VALUE_WIDTH-1:0] out_value_o,
  output logic [POS_W-1:0]              found_position_o,
  output logic [POS_W-1:0]              entry_count_o,
  output logic                          last_o
);
  import pol_pkg::*;

  logic signed [VALUE_WIDTH-1:0] cell_q [DEPTH];
  cell_sel_e                     cell_sel [DEPTH];

  pol_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .POS_W       (POS_W)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .item_value_i     (item_value_i),
    .item_position_i  (item_position_i),
    .cell_q_i         (cell_q),
    .cell_sel_o       (cell_sel),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .out_value_o      (out_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int PrevIdx = (g == 0) ? 0 : g - 1;
    localparam int NextIdx = (g == DEPTH - 1) ? g : g + 1;

    pol_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .sel_i   (cell_sel[g]),
      .value_i (item_value_i),
      .prev_i  (cell_q[PrevIdx]),
      .next_i  (cell_q[NextIdx]),
      .head_i  (cell_q[0]),
      .q_o     (cell_q[g])
    );
  end

endmodule
